@@ hdl/seven_segment_serial_display_writer_macros.svh @@
// Assertion macros shared by the display writer RTL files.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_WRITER_MACROS_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Same-edge implication, checked out of reset.
`define SSDW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssdw assertion failed");
// Next-edge implication, checked out of reset.
`define SSDW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssdw assertion failed");
`else
`define SSDW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSDW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/ssdw_pkg.sv @@
// Types, constants and the glyph table of the seven-segment display writer.
// No dependencies; ssdw_byte_sel, ssdw_seq and the top level import this package.
package ssdw_pkg;

  localparam int MAX_DIGITS = 6;

  // Sequencer phase codes.
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_BIT_LO   = 4'd3;
  localparam logic [3:0] PH_BIT_HI   = 4'd4;
  localparam logic [3:0] PH_ACK_LO   = 4'd5;
  localparam logic [3:0] PH_ACK_WAIT = 4'd6;
  localparam logic [3:0] PH_ACK_HI   = 4'd7;
  localparam logic [3:0] PH_ACK_END  = 4'd8;
  localparam logic [3:0] PH_STOP_A   = 4'd9;
  localparam logic [3:0] PH_STOP_B   = 4'd10;
  localparam logic [3:0] PH_STOP_C   = 4'd11;
  localparam logic [3:0] PH_STOP_D   = 4'd12;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_INIT    = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_HALF_BIT   = 3'd0;
  localparam logic [2:0] REG_SHORT_WAIT = 3'd1;
  localparam logic [2:0] REG_DATA_CMD   = 3'd2;
  localparam logic [2:0] REG_CTRL_CMD   = 3'd3;
  localparam logic [2:0] REG_DIGIT_CNT  = 3'd4;
  localparam logic [2:0] REG_ACK_TMO    = 3'd5;

  // Fixed bytes on the wire.
  localparam logic [7:0] ADDR_CMD_BYTE = 8'hC0;
  localparam logic [7:0] POINT_BIT     = 8'h80;
  localparam logic [2:0] NO_POINT      = 3'd6;

  typedef logic [MAX_DIGITS-1:0][3:0] ssdw_digits_t;

  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [15:0] short_wait_ticks;
    logic [7:0]  data_command;
    logic [7:0]  control_command;
    logic [2:0]  digit_count;
    logic [15:0] ack_timeout_ticks;
  } ssdw_cfg_t;

  typedef struct packed {
    logic [1:0]   operation;
    ssdw_digits_t digits;
    logic [2:0]   point_position;
    logic         dio_in;
  } ssdw_item_t;

  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic dio_release;
    logic busy_res;
    logic ack_error;
  } ssdw_res_t;

  // Segment pattern of a glyph code; unknown codes show blank.
  function automatic logic [7:0] glyph_seg(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:  seg = 8'h3F;
      4'd1:  seg = 8'h06;
      4'd2:  seg = 8'h5B;
      4'd3:  seg = 8'h4F;
      4'd4:  seg = 8'h66;
      4'd5:  seg = 8'h6D;
      4'd6:  seg = 8'h7D;
      4'd7:  seg = 8'h07;
      4'd8:  seg = 8'h7F;
      4'd9:  seg = 8'h6F;
      4'd10: seg = 8'h80;
      4'd11: seg = 8'h00;
      4'd12: seg = 8'h40;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Digit count clamped to one through MAX_DIGITS.
  function automatic logic [2:0] live_count(input logic [2:0] cnt);
    logic [2:0] n;
    n = cnt;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(MAX_DIGITS)) n = 3'(MAX_DIGITS);
    return n;
  endfunction

endpackage

@@ hdl/ssdw_if.sv @@
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on nothing; field widths are fixed by the pin-level protocol.
interface ssdw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] digit_0;
  logic [3:0] digit_1;
  logic [3:0] digit_2;
  logic [3:0] digit_3;
  logic [3:0] digit_4;
  logic [3:0] digit_5;
  logic [2:0] point_position;
  logic       dio_in;

  modport source (
    output valid, operation, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
           point_position, dio_in,
    input  ready
  );
  modport sink (
    input  valid, operation, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
           point_position, dio_in,
    output ready
  );
endinterface

interface ssdw_out_if;
  logic valid;
  logic ready;
  logic clk_out;
  logic dio_out;
  logic dio_release;
  logic busy_res;
  logic ack_error;

  modport source (
    output valid, clk_out, dio_out, dio_release, busy_res, ack_error,
    input  ready
  );
  modport sink (
    input  valid, clk_out, dio_out, dio_release, busy_res, ack_error,
    output ready
  );
endinterface

@@ hdl/ssdw_byte_sel.sv @@
// Picks the next byte to shift out: init commands, address command or a digit.
// Depends on ssdw_pkg for the glyph table and fixed bytes.
module ssdw_byte_sel (
  input  logic                 display_mode,
  input  logic [2:0]           byte_idx,
  input  logic [7:0]           data_command,
  input  logic [7:0]           control_command,
  input  ssdw_pkg::ssdw_digits_t digits,
  input  logic [2:0]           point,
  output logic [7:0]           byte_out
);
  import ssdw_pkg::*;

  logic [2:0] digit_idx;
  logic [7:0] seg;

  // Segment byte of the digit addressed by byte_idx - 1, with the point bit.
  always_comb begin
    digit_idx = byte_idx - 3'd1;
    seg = 8'h00;
    if (digit_idx < 3'(MAX_DIGITS)) begin
      seg = glyph_seg(digits[digit_idx]);
      if (point == digit_idx) begin
        seg = seg | POINT_BIT;
      end
    end
  end

  // Byte order: init sends two commands; a display write sends the address
  // command followed by one segment byte per digit.
  always_comb begin
    if (!display_mode) begin
      byte_out = (byte_idx == 3'd0) ? data_command : control_command;
    end else if (byte_idx == 3'd0) begin
      byte_out = ADDR_CMD_BYTE;
    end else begin
      byte_out = seg;
    end
  end

endmodule

@@ hdl/ssdw_seq.sv @@
// Pin sequencer: phase register, wait counter, bit shifter and latched digits.
// Depends on ssdw_pkg, ssdw_byte_sel and the assertion macro header.
`include "seven_segment_serial_display_writer_macros.svh"

module ssdw_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ssdw_pkg::ssdw_item_t item,
  input  ssdw_pkg::ssdw_cfg_t  cfg,
  output ssdw_pkg::ssdw_res_t  res
);
  import ssdw_pkg::*;

  logic [3:0]   phase_r, phase_nxt;
  logic [2:0]   bit_r, bit_nxt;
  logic [2:0]   byte_r, byte_nxt;
  logic [15:0]  wait_r, wait_nxt;
  logic [7:0]   shift_r, shift_nxt;
  ssdw_digits_t digits_r, digits_nxt;
  logic [2:0]   point_r, point_nxt;
  logic         clock_r, clock_nxt;
  logic         data_r, data_nxt;
  logic         display_r, display_nxt;

  logic         go;
  logic [3:0]   tgt;
  logic         err;
  logic [15:0]  poll_cnt;
  logic [2:0]   sel_idx;
  logic [7:0]   sel_byte;
  logic         rel;

  // The byte after an ack belongs to the next byte index.
  assign sel_idx = (phase_r == PH_ACK_END) ? (byte_r + 3'd1) : byte_r;

  ssdw_byte_sel u_byte_sel (
    .display_mode    (display_r),
    .byte_idx        (sel_idx),
    .data_command    (cfg.data_command),
    .control_command (cfg.control_command),
    .digits          (digits_r),
    .point           (point_r),
    .byte_out        (sel_byte)
  );

  // Next state for one tick.
  always_comb begin
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    byte_nxt    = byte_r;
    wait_nxt    = wait_r;
    shift_nxt   = shift_r;
    digits_nxt  = digits_r;
    point_nxt   = point_r;
    clock_nxt   = clock_r;
    data_nxt    = data_r;
    display_nxt = display_r;
    go          = 1'b0;
    tgt         = PH_IDLE;
    err         = 1'b0;
    poll_cnt    = (wait_r < 16'hFFFF) ? (wait_r + 16'd1) : wait_r;

    case (phase_r)
      PH_IDLE: begin
        if (item.operation == OP_INIT || item.operation == OP_DISPLAY) begin
          display_nxt = (item.operation == OP_DISPLAY);
          if (item.operation == OP_DISPLAY) begin
            digits_nxt = item.digits;
            point_nxt  = item.point_position;
          end
          byte_nxt = 3'd0;
          bit_nxt  = 3'd0;
          go       = 1'b1;
          tgt      = PH_START_A;
        end
      end
      PH_ACK_WAIT: begin
        if (!item.dio_in) begin
          go  = 1'b1;
          tgt = PH_ACK_HI;
        end else if (cfg.ack_timeout_ticks != 16'd0) begin
          wait_nxt = poll_cnt;
          if (poll_cnt >= cfg.ack_timeout_ticks) begin
            err = 1'b1;
            go  = 1'b1;
            tgt = PH_ACK_HI;
          end
        end
      end
      PH_START_A, PH_START_B, PH_BIT_LO, PH_BIT_HI, PH_ACK_LO, PH_ACK_HI,
      PH_ACK_END, PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_STOP_D: begin
        if (wait_r > 16'd1) begin
          wait_nxt = wait_r - 16'd1;
        end else begin
          go = 1'b1;
          case (phase_r)
            PH_START_A: tgt = PH_START_B;
            PH_START_B: begin
              shift_nxt = sel_byte;
              bit_nxt   = 3'd0;
              tgt       = PH_BIT_LO;
            end
            PH_BIT_LO: tgt = PH_BIT_HI;
            PH_BIT_HI: begin
              shift_nxt = {1'b0, shift_r[7:1]};
              if (bit_r == 3'd7) begin
                tgt = PH_ACK_LO;
              end else begin
                bit_nxt = bit_r + 3'd1;
                tgt     = PH_BIT_LO;
              end
            end
            PH_ACK_LO: tgt = PH_ACK_WAIT;
            PH_ACK_HI: tgt = PH_ACK_END;
            PH_ACK_END: begin
              if (display_r && byte_r < live_count(cfg.digit_count)) begin
                byte_nxt  = byte_r + 3'd1;
                shift_nxt = sel_byte;
                bit_nxt   = 3'd0;
                tgt       = PH_BIT_LO;
              end else begin
                tgt = PH_STOP_A;
              end
            end
            PH_STOP_A: tgt = PH_STOP_B;
            PH_STOP_B: tgt = PH_STOP_C;
            PH_STOP_C: tgt = PH_STOP_D;
            PH_STOP_D: begin
              // Init runs a second start/byte/stop frame for the control byte.
              if (!display_r && byte_r == 3'd0) begin
                byte_nxt = 3'd1;
                tgt      = PH_START_A;
              end else begin
                tgt = PH_IDLE;
              end
            end
            default: tgt = PH_IDLE;
          endcase
        end
      end
      default: begin
        go  = 1'b1;
        tgt = PH_IDLE;
      end
    endcase

    // Phase entry sets the pin levels and loads the wait counter.
    if (go) begin
      phase_nxt = tgt;
      wait_nxt  = 16'd1;
      case (tgt)
        PH_START_A: begin
          clock_nxt = 1'b1;
          data_nxt  = 1'b1;
          wait_nxt  = cfg.short_wait_ticks;
        end
        PH_START_B: data_nxt = 1'b0;
        PH_BIT_LO: begin
          clock_nxt = 1'b0;
          data_nxt  = shift_nxt[0];
          wait_nxt  = cfg.half_bit_ticks;
        end
        PH_BIT_HI: begin
          clock_nxt = 1'b1;
          wait_nxt  = cfg.half_bit_ticks;
        end
        PH_ACK_LO: begin
          clock_nxt = 1'b0;
          wait_nxt  = cfg.half_bit_ticks;
        end
        PH_ACK_WAIT: wait_nxt = 16'd0;
        PH_ACK_HI: begin
          clock_nxt = 1'b1;
          wait_nxt  = cfg.short_wait_ticks;
        end
        PH_ACK_END: begin
          clock_nxt = 1'b0;
          data_nxt  = 1'b0;
        end
        PH_STOP_A: begin
          clock_nxt = 1'b0;
          wait_nxt  = cfg.short_wait_ticks;
        end
        PH_STOP_B: begin
          data_nxt = 1'b0;
          wait_nxt = cfg.short_wait_ticks;
        end
        PH_STOP_C: begin
          clock_nxt = 1'b1;
          wait_nxt  = cfg.short_wait_ticks;
        end
        PH_STOP_D: data_nxt = 1'b1;
        default: begin
          phase_nxt = PH_IDLE;
          clock_nxt = 1'b1;
          data_nxt  = 1'b1;
          wait_nxt  = 16'd0;
        end
      endcase
    end
  end

  // Pin levels after this tick.
  always_comb begin
    rel = (phase_nxt == PH_ACK_LO) || (phase_nxt == PH_ACK_WAIT) || (phase_nxt == PH_ACK_HI);
    res.clk_out     = clock_nxt;
    res.dio_out     = rel ? 1'b1 : data_nxt;
    res.dio_release = rel;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.ack_error   = err;
  end

  // State registers advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_r     <= 3'd0;
      byte_r    <= 3'd0;
      wait_r    <= 16'd0;
      shift_r   <= 8'd0;
      digits_r  <= '0;
      point_r   <= NO_POINT;
      clock_r   <= 1'b1;
      data_r    <= 1'b1;
      display_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_r     <= bit_nxt;
      byte_r    <= byte_nxt;
      wait_r    <= wait_nxt;
      shift_r   <= shift_nxt;
      digits_r  <= digits_nxt;
      point_r   <= point_nxt;
      clock_r   <= clock_nxt;
      data_r    <= data_nxt;
      display_r <= display_nxt;
    end
  end

  // A timed-out ack can only come out of the ack polling phase.
  `SSDW_ASSERT_NOW(a_err_from_poll, clk, rst_n, step && res.ack_error, phase_r == PH_ACK_WAIT)
  // The data pin is only released while a sequence runs.
  `SSDW_ASSERT_NOW(a_rel_busy, clk, rst_n, res.dio_release, res.busy_res)
  // Byte index never passes the last digit.
  `SSDW_ASSERT_NOW(a_byte_range, clk, rst_n, 1'b1, byte_r <= 3'(MAX_DIGITS))

endmodule

@@ hdl/seven_segment_serial_display_writer.sv @@
// Two-wire seven-segment display writer. One input beat is one timing tick.
// Results are registered: a result beat is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless a result waits unread; the output register takes a new result while
// the previous one is read out in the same cycle.
// Reset: synchronous, active low; the sequencer returns to idle with both pins
// high and the configuration registers load their defaults.
`include "seven_segment_serial_display_writer_macros.svh"

module seven_segment_serial_display_writer (
  input  logic              clk,
  input  logic              rst_n,
  ssdw_in_if.sink           in_ch,
  ssdw_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import ssdw_pkg::*;

  ssdw_cfg_t  cfg_r;
  ssdw_item_t item;
  ssdw_res_t  res;
  ssdw_res_t  out_res_r;
  logic       out_valid_r;
  logic       accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks    <= 16'd50;
      cfg_r.short_wait_ticks  <= 16'd20;
      cfg_r.data_command      <= 8'h40;
      cfg_r.control_command   <= 8'h8A;
      cfg_r.digit_count       <= 3'd6;
      cfg_r.ack_timeout_ticks <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_BIT:   cfg_r.half_bit_ticks    <= cfg_data;
        REG_SHORT_WAIT: cfg_r.short_wait_ticks  <= cfg_data;
        REG_DATA_CMD:   cfg_r.data_command      <= cfg_data[7:0];
        REG_CTRL_CMD:   cfg_r.control_command   <= cfg_data[7:0];
        REG_DIGIT_CNT:  cfg_r.digit_count       <= cfg_data[2:0];
        REG_ACK_TMO:    cfg_r.ack_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake: take a beat whenever the output register is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign item.operation      = in_ch.operation;
  assign item.digits         = {in_ch.digit_5, in_ch.digit_4, in_ch.digit_3,
                                in_ch.digit_2, in_ch.digit_1, in_ch.digit_0};
  assign item.point_position = in_ch.point_position;
  assign item.dio_in         = in_ch.dio_in;

  ssdw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.clk_out     = out_res_r.clk_out;
  assign out_ch.dio_out     = out_res_r.dio_out;
  assign out_ch.dio_release = out_res_r.dio_release;
  assign out_ch.busy_res    = out_res_r.busy_res;
  assign out_ch.ack_error   = out_res_r.ack_error;

  // An empty output register never stalls the input.
  `SSDW_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid_r, in_ch.ready)
  // Every accepted beat leaves a result waiting in the next cycle.
  `SSDW_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, out_valid_r)
  // A result not taken stays in place.
  `SSDW_ASSERT_NEXT(a_hold_unread, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r)

endmodule
